@@ design/rc4_pkg.sv @@
// Shared types and constants for the RC4 keystream engine.
// No dependencies; imported by rc4_stream_cipher.
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int unsigned TableSize = 256;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned IdxW      = 8;
  localparam int unsigned KeyLenW   = 5;
  localparam int unsigned KeyPosW   = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_DATA  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_LOW    = 2'd0,
    REG_KEY_HIGH   = 2'd1,
    REG_KEY_LENGTH = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [ByteW-1:0] data_in;
  } in_beat_t;

  typedef struct packed {
    logic [ByteW-1:0] data_out;
    logic             unkeyed;
  } out_beat_t;

endpackage

@@ design/rc4_stream_cipher.sv @@
// RC4 keystream engine top level: sequencer, index registers, key registers.
// Depends on rc4_pkg and rc4_ram.
`timescale 1ns / 1ps
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  in       | in_valid_i, in_stall_o, in_data_i    | sink
//  out      | out_valid_o, out_stall_i, out_data_o | source
//  cfg      | cfg_we_i, cfg_index_i, cfg_wdata_i   | sink
//
//  Data beat: six memory steps plus result load, from accept to next accept.
//  Key schedule beat: 256 fill writes, then the states KRD_N, KRD_J, KWR_N, KWR_J for
//  each entry on the one RAM port pair. Index clear and unused op: no result.
//  Data beat while unkeyed: no memory access.
//  The result sits in an output register, so the next beat is taken while it waits;
//  a new result waits in the sequencer until that register is free.

module rc4_stream_cipher #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  rc4_pkg::in_beat_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output rc4_pkg::out_beat_t               out_data_o,
  input  logic                             cfg_we_i,
  input  logic [rc4_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rc4_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  import rc4_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_FILL  = 13'b0000000000010,
    ST_KRD_N = 13'b0000000000100,
    ST_KRD_J = 13'b0000000001000,
    ST_KWR_N = 13'b0000000010000,
    ST_KWR_J = 13'b0000000100000,
    ST_DRD_I = 13'b0000001000000,
    ST_DRD_J = 13'b0000010000000,
    ST_DWR_I = 13'b0000100000000,
    ST_DWR_J = 13'b0001000000000,
    ST_DRD_K = 13'b0010000000000,
    ST_DXOR  = 13'b0100000000000,
    ST_OUT   = 13'b1000000000000
  } state_e;

  localparam logic [KeyLenW-1:0] MaxLen = KeyLenW'(MAX_KEY_BYTES);

  state_e state_q, state_d;

  logic [IdxW-1:0]     i_q, i_d, j_q, j_d, n_q, n_d;
  logic [KeyPosW-1:0]  kpos_q, kpos_d;
  logic                keyed_q, keyed_d;
  logic [ByteW-1:0]    si_q, si_d, sj_q, sj_d;
  logic [ByteW-1:0]    din_q, din_d;
  logic [ByteW-1:0]    res_q, res_d;
  logic                unk_q, unk_d;
  logic                out_valid_q;
  out_beat_t           out_q;

  logic [CfgDataW-1:0] key_low_q, key_high_q;
  logic [KeyLenW-1:0]  key_len_q;
  logic [KeyLenW-1:0]  eff_len;
  logic [2*CfgDataW-1:0] key_all;
  logic [ByteW-1:0]    key_byte;

  logic [ByteW-1:0]    add_a, add_b, add_c, add_sum;

  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr, ram_raddr;
  logic [ByteW-1:0]    ram_wdata, ram_rdata;

  logic                in_accept, out_free;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (key_len_q == '0) begin
      eff_len = KeyLenW'(1);
    end else if (key_len_q > MaxLen) begin
      eff_len = MaxLen;
    end else begin
      eff_len = key_len_q;
    end
  end

  assign key_all  = {key_high_q, key_low_q};
  assign key_byte = key_all[{kpos_q, 3'b000} +: ByteW];

  // shared 8-bit adder for j and k updates
  assign add_sum = add_a + add_b + add_c;

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    n_d       = n_q;
    kpos_d    = kpos_q;
    keyed_d   = keyed_q;
    si_d      = si_q;
    sj_d      = sj_q;
    din_d     = din_q;
    res_d     = res_q;
    unk_d     = unk_q;
    add_a     = j_q;
    add_b     = ram_rdata;
    add_c     = '0;
    ram_we    = 1'b0;
    ram_waddr = n_q;
    ram_wdata = n_q;
    ram_raddr = n_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_data_i.op)
            OP_KEY: begin
              n_d     = '0;
              kpos_d  = '0;
              j_d     = '0;
              i_d     = '0;
              state_d = ST_FILL;
            end
            OP_DATA: begin
              din_d = in_data_i.data_in;
              if (keyed_q) begin
                i_d     = i_q + IdxW'(1);
                state_d = ST_DRD_I;
              end else begin
                res_d   = '0;
                unk_d   = 1'b1;
                state_d = ST_OUT;
              end
            end
            OP_CLEAR: begin
              i_d = '0;
              j_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
        n_d    = n_q + IdxW'(1);
        if (n_q == '1) begin
          state_d = ST_KRD_N;
        end
      end
      ST_KRD_N: begin
        state_d = ST_KRD_J;
      end
      ST_KRD_J: begin
        add_c     = key_byte;
        j_d       = add_sum;
        si_d      = ram_rdata;
        ram_raddr = add_sum;
        state_d   = ST_KWR_N;
      end
      ST_KWR_N: begin
        sj_d      = ram_rdata;
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        state_d   = ST_KWR_J;
      end
      ST_KWR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = si_q;
        n_d       = n_q + IdxW'(1);
        if ({1'b0, kpos_q} + KeyLenW'(1) == eff_len) begin
          kpos_d = '0;
        end else begin
          kpos_d = kpos_q + KeyPosW'(1);
        end
        if (n_q == '1) begin
          keyed_d = 1'b1;
          i_d     = '0;
          j_d     = '0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_KRD_N;
        end
      end
      ST_DRD_I: begin
        ram_raddr = i_q;
        state_d   = ST_DRD_J;
      end
      ST_DRD_J: begin
        j_d       = add_sum;
        si_d      = ram_rdata;
        ram_raddr = add_sum;
        state_d   = ST_DWR_I;
      end
      ST_DWR_I: begin
        sj_d      = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
        state_d   = ST_DWR_J;
      end
      ST_DWR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = si_q;
        state_d   = ST_DRD_K;
      end
      ST_DRD_K: begin
        add_a     = si_q;
        add_b     = sj_q;
        ram_raddr = add_sum;
        state_d   = ST_DXOR;
      end
      ST_DXOR: begin
        res_d   = din_q ^ ram_rdata;
        unk_d   = 1'b0;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
      key_low_q   <= '0;
      key_high_q  <= '0;
      key_len_q   <= KeyLenW'(16);
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      keyed_q <= keyed_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_KEY_LOW:    key_low_q  <= cfg_wdata_i;
          REG_KEY_HIGH:   key_high_q <= cfg_wdata_i;
          REG_KEY_LENGTH: key_len_q  <= cfg_wdata_i[KeyLenW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    kpos_q <= kpos_d;
    si_q   <= si_d;
    sj_q   <= sj_d;
    din_q  <= din_d;
    res_q  <= res_d;
    unk_q  <= unk_d;
    if (state_q == ST_OUT && out_free) begin
      out_q.data_out <= res_q;
      out_q.unkeyed  <= unk_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  rc4_ram #(
    .WIDTH(ByteW),
    .DEPTH(TableSize)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_keyed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keyed_q |=> keyed_q)
    else $error("keyed flag dropped");

  a_unkeyed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.unkeyed) |-> (out_data_o.data_out == '0))
    else $error("unkeyed beat carries data");

  a_ks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KWR_J && n_q == '1) |=> (keyed_q && i_q == '0 && j_q == '0))
    else $error("key schedule end did not clear indices");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != ST_IDLE && state_q != ST_OUT))
    else $error("table write outside a sequence");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result not loaded");

endmodule

@@ design/rc4_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the RC4 permutation store.
`timescale 1ns / 1ps

module rc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/tb_rc4_stream_cipher.sv @@
// Self-checking testbench for rc4_stream_cipher: queued beats, a key schedule and
// keystream predictor, and a result checker. Depends on rc4_pkg and the RTL.
`timescale 1ns / 1ps

module tb_rc4_stream_cipher;
  import rc4_pkg::*;

  localparam int unsigned MaxKeyBytes = 16;
  localparam int unsigned SegBeats = 45;
  localparam int unsigned SettleCycles = 2000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned StuckLimit = 20000;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_beat = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_beat;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  in_beat_t in_beats_q[$];
  out_beat_t cipher_bytes_q[$];

  // predictor state
  logic [7:0] perm_q[TableSize];
  logic [7:0] idx_i = '0;
  logic [7:0] idx_j = '0;
  logic keyed = 1'b0;
  logic [63:0] key_low = '0;
  logic [63:0] key_high = '0;
  logic [4:0] key_len = 5'd16;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned stuck_cnt = 0;

  rc4_stream_cipher #(
    .MAX_KEY_BYTES(MaxKeyBytes)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_beat),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic void rc4_step(in_beat_t b);
    out_beat_t r;
    logic [127:0] key;
    logic [7:0] jj;
    logic [7:0] t;
    logic [7:0] k;
    int unsigned len;
    case (b.op)
      OP_KEY: begin
        key = {key_high, key_low};
        len = 32'(key_len);
        if (len == 0) len = 1;
        if (len > MaxKeyBytes) len = MaxKeyBytes;
        for (int n = 0; n < TableSize; n++) perm_q[n] = n[7:0];
        jj = '0;
        for (int n = 0; n < TableSize; n++) begin
          jj = jj + perm_q[n] + key[(n % len) * 8 +: 8];
          t = perm_q[n];
          perm_q[n] = perm_q[jj];
          perm_q[jj] = t;
        end
        idx_i = '0;
        idx_j = '0;
        keyed = 1'b1;
      end
      OP_CLEAR: begin
        idx_i = '0;
        idx_j = '0;
      end
      OP_DATA: begin
        if (!keyed) begin
          r.data_out = '0;
          r.unkeyed = 1'b1;
        end else begin
          idx_i = idx_i + 8'd1;
          idx_j = idx_j + perm_q[idx_i];
          t = perm_q[idx_i];
          perm_q[idx_i] = perm_q[idx_j];
          perm_q[idx_j] = t;
          k = perm_q[idx_i] + perm_q[idx_j];
          r.data_out = b.data_in ^ perm_q[k];
          r.unkeyed = 1'b0;
        end
        cipher_bytes_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_beat <= '0;
    end else begin
      if (in_valid && !in_stall) rc4_step(in_beat);
      if (!in_valid || !in_stall) begin
        if (in_beats_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_beat <= in_beats_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t exp_beat;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_ack <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cipher_bytes_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected beat: data_out=%h unkeyed=%b", out_beat.data_out,
                     out_beat.unkeyed);
        end else begin
          exp_beat = cipher_bytes_q.pop_front();
          if (out_beat.data_out !== exp_beat.data_out ||
              out_beat.unkeyed !== exp_beat.unkeyed) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("beat mismatch: exp data_out=%h unkeyed=%b, got data_out=%h unkeyed=%b",
                       exp_beat.data_out, exp_beat.unkeyed, out_beat.data_out,
                       out_beat.unkeyed);
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        hold_left <= HoldCycles;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cnt <= 0;
    else stuck_cnt <= stuck_cnt + 1;
    if (stuck_cnt >= StuckLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic add_beat(input logic [1:0] op, input logic [7:0] data);
    in_beat_t b;
    b.op = op;
    b.data_in = data;
    in_beats_q.push_back(b);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_KEY_LOW: key_low = value;
      REG_KEY_HIGH: key_high = value;
      REG_KEY_LENGTH: key_len = value[4:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait until the block is idle, including a key schedule with no result
  task automatic drain();
    while (in_beats_q.size() > 0 || in_valid || cipher_bytes_q.size() > 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    logic [63:0] wd;
    int unsigned r;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // unkeyed, unused op and clears, then the reset key (all zero, 16 bytes)
    add_beat(OP_DATA, 8'h00);
    add_beat(OP_DATA, 8'hFF);
    add_beat(OP_CLEAR, 8'h00);
    add_beat(OpUnused, 8'h5A);
    add_beat(OP_DATA, 8'hA5);
    add_beat(OP_KEY, 8'hFF);
    add_beat(OP_DATA, 8'h00);
    add_beat(OP_DATA, 8'hFF);
    add_beat(OP_DATA, 8'h55);
    add_beat(OP_DATA, 8'hAA);
    add_beat(OpUnused, 8'hA5);
    add_beat(OP_CLEAR, 8'hFF);
    add_beat(OP_DATA, 8'h3C);
    add_beat(OP_DATA, 8'hC3);

    // key length zero acts as one
    drain();
    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LENGTH, 64'd0);
    write_reg(RegUnused, 64'hDEAD_BEEF_0BAD_F00D);
    add_beat(OP_KEY, 8'h00);
    add_beat(OP_DATA, 8'h12);
    add_beat(OP_DATA, 8'hED);

    // length above the maximum saturates
    drain();
    write_reg(REG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_KEY_HIGH, 64'hFEDC_BA98_7654_3210);
    write_reg(REG_KEY_LENGTH, 64'd31);
    add_beat(OP_KEY, 8'h00);
    add_beat(OP_DATA, 8'h80);
    add_beat(OP_DATA, 8'h01);

    drain();
    write_reg(REG_KEY_LENGTH, 64'd1);
    add_beat(OP_KEY, 8'h00);
    add_beat(OP_DATA, 8'h7F);

    // new key registers must not disturb the running keystream
    drain();
    write_reg(REG_KEY_LOW, 64'h0);
    write_reg(REG_KEY_LENGTH, 64'd17);
    add_beat(OP_DATA, 8'hFE);
    add_beat(OP_KEY, 8'h00);
    add_beat(OP_DATA, 8'h99);

    for (int ph = 0; ph < 4; ph++) begin
      for (int seg = 0; seg < 3; seg++) begin
        drain();
        case (ph)
          0: begin send_idle_pct = 0; recv_stall_pct = 0; end
          1: begin send_idle_pct = 77; recv_stall_pct = 0; end
          2: begin send_idle_pct = 0; recv_stall_pct = 77; end
          default: begin send_idle_pct = 34; recv_stall_pct = 34; end
        endcase
        write_reg(REG_KEY_LOW, {$urandom, $urandom});
        write_reg(REG_KEY_HIGH, {$urandom, $urandom});
        wd = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 70) wd[4:0] = 5'($urandom_range(1, MaxKeyBytes));
        else if (r < 80) wd[4:0] = 5'd0;
        else wd[4:0] = 5'($urandom_range(MaxKeyBytes + 1, 31));
        write_reg(REG_KEY_LENGTH, wd);
        add_beat(OP_KEY, 8'($urandom_range(0, 255)));
        for (int n = 1; n < SegBeats; n++) begin
          r = $urandom_range(0, 99);
          if (r < 84) add_beat(OP_DATA, 8'($urandom_range(0, 255)));
          else if (r < 92) add_beat(OP_CLEAR, 8'($urandom_range(0, 255)));
          else if (r < 97) add_beat(OpUnused, 8'($urandom_range(0, 255)));
          else add_beat(OP_KEY, 8'($urandom_range(0, 255)));
        end
        if (ph == 0 && seg == 1) begin
          // back-pressure the output long enough for the input to stall
          while (in_beats_q.size() > SegBeats - 8) @(negedge clk_i);
          hold_req = ~hold_req;
        end
      end
    end

    drain();
    if (mismatch_cnt == 0 && cipher_bytes_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
